// File: rtl/hte_pkg.sv
// ---------------------------------------------------------------------------
// hte_pkg: shared types and constants of the markup text filter
// Word format between stages, entity cell definitions and character codes.
// ---------------------------------------------------------------------------
package hte_pkg;

   // one word between stages: a byte, or the end marker (last set, data zero)
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } word_type;

   // entity cell definition: pattern bytes (index 0 first), length, decoded byte
   typedef struct packed {
      logic [5:0][7:0] pat;
      logic [2:0]      len;
      logic [7:0]      repl;
   } cell_def_type;

   localparam int CELL_COUNT = 9;

   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   // cells in chain order: amp quot #x27 #39 lt gt nbsp #x2F apos
   localparam cell_def_type CELL_DEFS [CELL_COUNT] = '{
      '{pat: {8'h00, ";", "p", "m", "a", "&"}, len: 3'd5, repl: "&"},
      '{pat: {";", "t", "o", "u", "q", "&"},   len: 3'd6, repl: "\""},
      '{pat: {";", "7", "2", "x", "#", "&"},   len: 3'd6, repl: "'"},
      '{pat: {8'h00, ";", "9", "3", "#", "&"}, len: 3'd5, repl: "'"},
      '{pat: {8'h00, 8'h00, ";", "t", "l", "&"}, len: 3'd4, repl: "<"},
      '{pat: {8'h00, 8'h00, ";", "t", "g", "&"}, len: 3'd4, repl: ">"},
      '{pat: {";", "p", "s", "b", "n", "&"},   len: 3'd6, repl: " "},
      '{pat: {";", "F", "2", "x", "#", "&"},   len: 3'd6, repl: "/"},
      '{pat: {";", "s", "o", "p", "a", "&"},   len: 3'd6, repl: "'"}
   };

endpackage

// File: rtl/hte_skid.sv
// ---------------------------------------------------------------------------
// hte_skid: two-entry output stage
// Output register plus skid register; full is registered so that a stage's
// ready never depends combinationally on its downstream neighbour.
// ---------------------------------------------------------------------------
module hte_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hte_pkg::word_type push_word,
   output logic              full,
   output logic              out_valid,
   output hte_pkg::word_type out_word,
   input  logic              out_ready
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   hte_pkg::word_type main_word_ff, main_word_in;
   hte_pkg::word_type skid_word_ff, skid_word_in;
   logic              take;

   assign take      = main_valid_ff & out_ready;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_word  = main_word_ff;

   // next state: skid refills main, else a push lands in main or skid
   always_comb begin
      main_valid_in = main_valid_ff;
      main_word_in  = main_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_word_in  = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (main_valid_ff && !take) begin
         if (push) begin
            skid_valid_in = 1'b1;
            skid_word_in  = push_word;
         end
      end else begin
         main_valid_in = push;
         if (push) begin
            main_word_in = push_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_word_ff <= main_word_in;
      skid_word_ff <= skid_word_in;
   end

   // skid only fills behind a held output word
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid word without output word");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(main_valid_ff && !out_ready))
      else $error("skid filled while output was free");

endmodule

// File: rtl/hte_strip.sv
// ---------------------------------------------------------------------------
// hte_strip: tag strip stage
// Drops tag contents, turns '<' into a space and splits a byte carrying the
// end flag into a byte word followed by an end word.
// ---------------------------------------------------------------------------
module hte_strip (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_in_byte,
   input  logic              req_byte_present,
   input  logic              req_end_of_input,
   output logic              out_valid,
   output hte_pkg::word_type out_word,
   input  logic              out_ready
);

   logic              inside_tag_ff, inside_tag_in;
   logic              pend_end_ff, pend_end_in;
   logic              full;
   logic              accept;
   logic              byte_emit;
   logic              push;
   hte_pkg::word_type push_word;

   assign req_ready = !full && !pend_end_ff;
   assign accept    = req_valid && req_ready;

   // decide what a byte produces and how the tag flag moves
   always_comb begin
      byte_emit     = 1'b0;
      inside_tag_in = inside_tag_ff;
      pend_end_in   = pend_end_ff;
      push          = 1'b0;
      push_word     = '0;
      if (pend_end_ff && !full) begin
         push           = 1'b1;
         push_word.last = 1'b1;
         pend_end_in    = 1'b0;
      end else if (accept) begin
         if (req_byte_present) begin
            if (req_in_byte == hte_pkg::CHAR_LT) begin
               inside_tag_in = 1'b1;
               byte_emit     = 1'b1;
            end else if (req_in_byte == hte_pkg::CHAR_GT) begin
               inside_tag_in = 1'b0;
            end else begin
               byte_emit = !inside_tag_ff;
            end
         end
         if (byte_emit) begin
            push           = 1'b1;
            push_word.data = (req_in_byte == hte_pkg::CHAR_LT) ?
                             hte_pkg::CHAR_SPACE : req_in_byte;
            pend_end_in    = req_end_of_input;
         end else if (req_end_of_input) begin
            push           = 1'b1;
            push_word.last = 1'b1;
         end
         if (req_end_of_input) begin
            inside_tag_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_tag_ff <= 1'b0;
         pend_end_ff   <= 1'b0;
      end else begin
         inside_tag_ff <= inside_tag_in;
         pend_end_ff   <= pend_end_in;
      end
   end

   hte_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (full),
      .out_valid (out_valid),
      .out_word  (out_word),
      .out_ready (out_ready)
   );

endmodule

// File: rtl/hte_cell.sv
// ---------------------------------------------------------------------------
// hte_cell: one entity replacement cell
// Holds the matched prefix of its pattern; on a full match sends the decoded
// byte, on mismatch or end word releases prefix bytes one a cycle unless full.
// ---------------------------------------------------------------------------
module hte_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  hte_pkg::cell_def_type cell_def,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  hte_pkg::word_type     up_word,
   output logic                  out_valid,
   output hte_pkg::word_type     out_word,
   input  logic                  out_ready
);

   logic              hold_valid_ff;
   hte_pkg::word_type hold_word_ff;
   logic [2:0]        match_len_ff, match_len_in;
   logic [2:0]        rel_ff, rel_in;
   logic              full;
   logic              step;
   logic              consume;
   logic              push;
   hte_pkg::word_type push_word;
   logic [7:0]        rel_byte;
   logic [7:0]        next_pat_byte;

   assign step          = hold_valid_ff && !full;
   assign up_ready      = !hold_valid_ff || consume;
   assign rel_byte      = cell_def.pat[rel_ff];
   assign next_pat_byte = cell_def.pat[match_len_ff];

   // one action per cycle on the held word while the output register has room
   always_comb begin
      consume      = 1'b0;
      push         = 1'b0;
      push_word    = '0;
      match_len_in = match_len_ff;
      rel_in       = rel_ff;
      if (step) begin
         if (hold_word_ff.last) begin
            push = 1'b1;
            if (rel_ff < match_len_ff) begin
               push_word.data = rel_byte;
               rel_in         = rel_ff + 3'd1;
            end else begin
               push_word.last = 1'b1;
               match_len_in   = '0;
               rel_in         = '0;
               consume        = 1'b1;
            end
         end else if (hold_word_ff.data == next_pat_byte) begin
            consume = 1'b1;
            if (match_len_ff + 3'd1 == cell_def.len) begin
               push           = 1'b1;
               push_word.data = cell_def.repl;
               match_len_in   = '0;
            end else begin
               match_len_in = match_len_ff + 3'd1;
            end
         end else if (rel_ff < match_len_ff) begin
            push           = 1'b1;
            push_word.data = rel_byte;
            rel_in         = rel_ff + 3'd1;
         end else begin
            consume = 1'b1;
            rel_in  = '0;
            if (hold_word_ff.data == hte_pkg::CHAR_AMP) begin
               // a fresh match starts on this ampersand
               match_len_in = 3'd1;
            end else begin
               match_len_in   = '0;
               push           = 1'b1;
               push_word.data = hold_word_ff.data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         match_len_ff  <= '0;
         rel_ff        <= '0;
      end else begin
         match_len_ff <= match_len_in;
         rel_ff       <= rel_in;
         if (up_valid && up_ready) begin
            hold_valid_ff <= 1'b1;
         end else if (consume) begin
            hold_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         hold_word_ff <= up_word;
      end
   end

   hte_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (full),
      .out_valid (out_valid),
      .out_word  (out_word),
      .out_ready (out_ready)
   );

   a_prefix_short: assert property (@(posedge clock) disable iff (reset)
      match_len_ff < cell_def.len)
      else $error("held prefix reached full pattern length");

   a_release_bounded: assert property (@(posedge clock) disable iff (reset)
      rel_ff <= match_len_ff)
      else $error("released more bytes than held");

   a_release_has_word: assert property (@(posedge clock) disable iff (reset)
      (rel_ff != 3'd0) |-> hold_valid_ff)
      else $error("prefix release without a held word");

endmodule

// File: rtl/hte_collapse.sv
// ---------------------------------------------------------------------------
// hte_collapse: whitespace collapse stage
// Drops leading and trailing whitespace runs, turns inner runs into one
// space and forms the end marker.
// ---------------------------------------------------------------------------
module hte_collapse (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   output logic              up_ready,
   input  hte_pkg::word_type up_word,
   output logic              out_valid,
   output hte_pkg::word_type out_word,
   input  logic              out_ready
);

   logic              hold_valid_ff;
   hte_pkg::word_type hold_word_ff;
   logic              space_pending_ff, space_pending_in;
   logic              text_started_ff, text_started_in;
   logic              full;
   logic              step;
   logic              consume;
   logic              is_ws;
   logic              push;
   hte_pkg::word_type push_word;

   assign step     = hold_valid_ff && !full;
   assign up_ready = !hold_valid_ff || consume;
   assign is_ws    = (hold_word_ff.data == hte_pkg::CHAR_SPACE) ||
                     ((hold_word_ff.data >= hte_pkg::CHAR_TAB) &&
                      (hold_word_ff.data <= hte_pkg::CHAR_CR));

   // one action per cycle while the output register has room; a pending space goes out before the next byte
   always_comb begin
      consume          = 1'b0;
      push             = 1'b0;
      push_word        = '0;
      space_pending_in = space_pending_ff;
      text_started_in  = text_started_ff;
      if (step) begin
         if (hold_word_ff.last) begin
            push             = 1'b1;
            push_word.last   = 1'b1;
            space_pending_in = 1'b0;
            text_started_in  = 1'b0;
            consume          = 1'b1;
         end else if (is_ws) begin
            space_pending_in = text_started_ff;
            consume          = 1'b1;
         end else if (space_pending_ff) begin
            push             = 1'b1;
            push_word.data   = hte_pkg::CHAR_SPACE;
            space_pending_in = 1'b0;
         end else begin
            push            = 1'b1;
            push_word.data  = hold_word_ff.data;
            text_started_in = 1'b1;
            consume         = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff    <= 1'b0;
         space_pending_ff <= 1'b0;
         text_started_ff  <= 1'b0;
      end else begin
         space_pending_ff <= space_pending_in;
         text_started_ff  <= text_started_in;
         if (up_valid && up_ready) begin
            hold_valid_ff <= 1'b1;
         end else if (consume) begin
            hold_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         hold_word_ff <= up_word;
      end
   end

   hte_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (full),
      .out_valid (out_valid),
      .out_word  (out_word),
      .out_ready (out_ready)
   );

   a_pending_needs_text: assert property (@(posedge clock) disable iff (reset)
      space_pending_ff |-> text_started_ff)
      else $error("space pending before any text");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (step && hold_word_ff.last) |=> (!space_pending_ff && !text_started_ff))
      else $error("end word did not clear collapse state");

endmodule

// File: rtl/html_text_extract_filter.sv
// ---------------------------------------------------------------------------
// html_text_extract_filter: markup to plain text filter
// Tag strip, a chain of nine entity decode cells, then whitespace collapse.
//
//   channel  dir  handshake             word
//   req_     in   req_valid/req_ready   in_byte, byte_present, end_of_input
//   rsp_     out  rsp_valid/rsp_ready   out_byte, char_present, end_of_text
//
// One input word a cycle while no stage holds the flow; each stage handles one
// word a cycle while its output register has room. A cell releases a held
// prefix byte by byte before it takes the next word, the collapse sends a
// pending space before the next text byte, and the strip splits a byte with
// the end flag into a byte word and an end word. A word passes the strip's
// output register, and in each cell and the collapse a hold then an output register.
// Reset is synchronous and clears all match and tag state; no clearing pass.
// Every stage ends in a two-entry output register, so stalls back up word by
// word and ready never ripples combinationally along the chain.
// ---------------------------------------------------------------------------
module html_text_extract_filter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_byte_present,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_char_present,
   output logic       rsp_end_of_text
);

   hte_pkg::word_type                 link_word [hte_pkg::CELL_COUNT+1];
   logic [hte_pkg::CELL_COUNT:0]      link_valid;
   logic [hte_pkg::CELL_COUNT:0]      link_ready;
   hte_pkg::word_type                 rsp_word;

   // tag strip at the head of the chain
   hte_strip u_strip (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_byte_present (req_byte_present),
      .req_end_of_input (req_end_of_input),
      .out_valid        (link_valid[0]),
      .out_word         (link_word[0]),
      .out_ready        (link_ready[0])
   );

   // entity cells in fixed order
   for (genvar k = 0; k < hte_pkg::CELL_COUNT; k++) begin : g_cell
      hte_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_def  (hte_pkg::CELL_DEFS[k]),
         .up_valid  (link_valid[k]),
         .up_ready  (link_ready[k]),
         .up_word   (link_word[k]),
         .out_valid (link_valid[k+1]),
         .out_word  (link_word[k+1]),
         .out_ready (link_ready[k+1])
      );
   end

   // whitespace collapse drives the result port
   hte_collapse u_collapse (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (link_valid[hte_pkg::CELL_COUNT]),
      .up_ready  (link_ready[hte_pkg::CELL_COUNT]),
      .up_word   (link_word[hte_pkg::CELL_COUNT]),
      .out_valid (rsp_valid),
      .out_word  (rsp_word),
      .out_ready (rsp_ready)
   );

   assign rsp_out_byte     = rsp_word.data;
   assign rsp_char_present = !rsp_word.last;
   assign rsp_end_of_text  = rsp_word.last;

endmodule
